// File: rtl/core/uidl_pkg.sv
package uidl_pkg;

  // list geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 32;
  localparam int CAP_W  = 5;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // request codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_ENTRY     = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;

endpackage

// File: rtl/core/unique_id_list_table.sv
// Ordered list of unique 32-bit IDs held in a single-port-read, single-port-write
// RAM of uidl_pkg::DEPTH entries. A request is taken when start is high and busy
// is low. Full refusals, adds to an empty list, removes from an empty list, list
// requests on an empty list and the unused code finish at once: busy never rises,
// the result, if any (none for the unused code), appears the next cycle and a
// new request is taken every cycle. Any other request walks the stored entries
// through the RAM read port, one per cycle, and keeps busy high until its final
// result is shown. An add that meets its duplicate in slot i stops the walk
// there. Duplicate search, compaction after a remove and listing all ride on
// this one walk; compaction writes each entry back one slot lower as it is read.
// Results are shown for exactly one cycle on out_valid and cannot be held off;
// a list request streams its entries on consecutive cycles with out_last on the
// final one. Capacity is written through cfg_we/cfg_wdata; the user must write
// it only while idle (not enforced by the block); values above DEPTH act as DEPTH.
module unique_id_list_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_operation,
  input  logic signed [uidl_pkg::ID_W-1:0] in_task_id,
  output logic                         out_valid,
  output logic [2:0]                   out_status,
  output logic signed [uidl_pkg::ID_W-1:0] out_entry_id,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [uidl_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int IDX_W = uidl_pkg::IDX_W;
  localparam int CNT_W = uidl_pkg::CNT_W;
  localparam int ID_W  = uidl_pkg::ID_W;
  localparam int CMP_W = uidl_pkg::CMP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                     state_r, state_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [ID_W-1:0]          id_r, id_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [uidl_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]         iss_r, iss_nxt;
  logic [IDX_W-1:0]         pidx_r, pidx_nxt;
  logic                     pvld_r, pvld_nxt;
  logic                     shift_r, shift_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [2:0]               out_status_r, out_status_nxt;
  logic [ID_W-1:0]          out_entry_r, out_entry_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     ram_we, ram_re;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [ID_W-1:0]          ram_wdata, ram_rdata;

  logic [CMP_W-1:0]         eff_cap;
  logic                     at_cap;
  logic                     is_last;

  uidl_ram #(
    .DATA_W (ID_W),
    .ADDR_W (IDX_W),
    .DEPTH_P(uidl_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // capacity saturated to the store depth
  always_comb begin
    if (CMP_W'(cap_r) > CMP_W'(uidl_pkg::DEPTH)) begin
      eff_cap = CMP_W'(uidl_pkg::DEPTH);
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
    at_cap  = (CMP_W'(cnt_r) >= eff_cap);
    is_last = ((CNT_W'(pidx_r) + CNT_W'(1)) == cnt_r);
  end

  // request sequencer: accept, walk the store, finish
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    cnt_nxt        = cnt_r;
    iss_nxt        = iss_r;
    pidx_nxt       = pidx_r;
    pvld_nxt       = 1'b0;
    shift_nxt      = shift_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_entry_nxt  = '0;
    out_last_nxt   = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = pidx_r - IDX_W'(1);
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = iss_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          id_nxt    = in_task_id;
          iss_nxt   = '0;
          shift_nxt = 1'b0;
          unique case (in_operation)
            uidl_pkg::OP_ADD: begin
              if (at_cap) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = uidl_pkg::ST_FULL;
              end else if (cnt_r == '0) begin
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata      = in_task_id;
                cnt_nxt        = cnt_r + CNT_W'(1);
                out_valid_nxt  = 1'b1;
                out_status_nxt = uidl_pkg::ST_ADDED;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            uidl_pkg::OP_REMOVE: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = uidl_pkg::ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            uidl_pkg::OP_LIST: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = uidl_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // unused code: no result, no change
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next read while entries remain
        if (iss_r < cnt_r) begin
          ram_re   = 1'b1;
          iss_nxt  = iss_r + CNT_W'(1);
          pvld_nxt = 1'b1;
          pidx_nxt = iss_r[IDX_W-1:0];
        end

        // handle the entry read last cycle
        if (pvld_r) begin
          unique case (op_r)
            uidl_pkg::OP_ADD: begin
              if (ram_rdata == id_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = uidl_pkg::ST_DUPLICATE;
                state_nxt      = S_IDLE;
              end else if (is_last) begin
                ram_we         = 1'b1;
                ram_waddr      = cnt_r[IDX_W-1:0];
                ram_wdata      = id_r;
                cnt_nxt        = cnt_r + CNT_W'(1);
                out_valid_nxt  = 1'b1;
                out_status_nxt = uidl_pkg::ST_ADDED;
                state_nxt      = S_IDLE;
              end
            end
            uidl_pkg::OP_REMOVE: begin
              if (shift_r) begin
                // compaction: move this entry one slot down
                ram_we = 1'b1;
                if (is_last) begin
                  cnt_nxt        = cnt_r - CNT_W'(1);
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = uidl_pkg::ST_REMOVED;
                  state_nxt      = S_IDLE;
                end
              end else if (ram_rdata == id_r) begin
                if (is_last) begin
                  cnt_nxt        = cnt_r - CNT_W'(1);
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = uidl_pkg::ST_REMOVED;
                  state_nxt      = S_IDLE;
                end else begin
                  shift_nxt = 1'b1;
                end
              end else if (is_last) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = uidl_pkg::ST_NOT_FOUND;
                state_nxt      = S_IDLE;
              end
            end
            default: begin
              // list: stream each entry
              out_valid_nxt  = 1'b1;
              out_status_nxt = uidl_pkg::ST_ENTRY;
              out_entry_nxt  = ram_rdata;
              out_last_nxt   = is_last;
              if (is_last) begin
                state_nxt = S_IDLE;
              end
            end
          endcase
          if (state_nxt == S_IDLE) begin
            pvld_nxt = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= uidl_pkg::CAP_RESET;
      pvld_r      <= 1'b0;
      shift_r     <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pvld_r      <= pvld_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    pidx_r       <= pidx_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy         = (state_r == S_SCAN);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_entry_id = out_entry_r;
  assign out_last     = out_last_r;

endmodule

// File: rtl/core/uidl_ram.sv
module uidl_ram #(
  parameter int DATA_W  = 32,
  parameter int ADDR_W  = 4,
  parameter int DEPTH_P = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH_P];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/uidl_checker.sv
module uidl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   in_operation,
  input logic                         out_valid,
  input logic [2:0]                   out_status,
  input logic                         out_last
);

  // only listed entries can be followed by more results of the same request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != uidl_pkg::ST_ENTRY) |-> out_last)
    else $error("non-entry result without last");

  // a listing streams without gaps
  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside listing");

  // idle with no request gives no result next cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !out_valid)
    else $error("result without request");

  // the unused code is dropped silently
  a_unused_code: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == uidl_pkg::OP_NONE) |=> (!out_valid && !busy))
    else $error("unused code produced activity");

  // a walk always ends with the final result of its request
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last))
    else $error("busy dropped without final result");

endmodule

bind unique_id_list_table uidl_checker u_uidl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_operation(in_operation),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_last    (out_last)
);
